// ===== rtl/core/plt_pkg.sv =====
// Shared types and constants for the positional list table.
// No dependencies; imported by every module of the block.
package plt_pkg;

    localparam int CAPACITY_DEF = 64;   // default slot count
    localparam int GROUP_SIZE   = 8;    // cells per first-level gather group

    localparam int TYPE_W   = 3;
    localparam int POS_W    = 16;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_READ   = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // operation broadcast to every cell for one transaction
    typedef struct packed {
        logic ins;   // open a hole at the index and write data there
        logic rem;   // close the slot at the index, later entries move down
        logic rd;    // capture the slot at the index for the gather tree
    } cell_ctrl_t;

endpackage

// ===== rtl/core/plt_cell.sv =====
// One slot of the list: holds a value and trades it with its neighbors.
// Depends on plt_pkg.
module plt_cell
    import plt_pkg::*;
#(
    parameter int IDX_W = 6,
    parameter int IDX   = 0
)
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [IDX_W-1:0]  at,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [DATA_W-1:0] prev_data,   // from slot IDX-1
    input  logic [DATA_W-1:0] next_data,   // from slot IDX+1
    output logic [DATA_W-1:0] slot_data,
    output logic [DATA_W-1:0] hit_data
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [DATA_W-1:0] slot_reg;
    logic [DATA_W-1:0] slot_next;
    logic [DATA_W-1:0] hit_reg;
    logic [DATA_W-1:0] hit_next;

    always_comb
    begin
        slot_next = slot_reg;
        if (ctrl.ins)
        begin
            if (MY_IDX == at)
                slot_next = wr_data;
            else if (MY_IDX > at)
                slot_next = prev_data;
        end
        else if (ctrl.rem)
        begin
            if (MY_IDX >= at)
                slot_next = next_data;
        end
    end

    // non-matching cells contribute zero to the OR tree
    assign hit_next = (ctrl.rd && (MY_IDX == at)) ? slot_reg : '0;

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        hit_reg  <= hit_next;
    end

    assign slot_data = slot_reg;
    assign hit_data  = hit_reg;

endmodule

// ===== rtl/core/plt_gather.sv =====
// Two-level read gather: ORs groups of cell hit words into registers,
// then ORs the group registers. Depends on plt_pkg.
module plt_gather
    import plt_pkg::*;
#(
    parameter int NUM_CELLS = CAPACITY_DEF
)
(
    input  logic              clk,
    input  logic              load,
    input  logic [DATA_W-1:0] hit_data [NUM_CELLS],
    output logic [DATA_W-1:0] gather_data
);

    localparam int NUM_GROUPS = (NUM_CELLS + GROUP_SIZE - 1) / GROUP_SIZE;

    logic [DATA_W-1:0] grp_reg  [NUM_GROUPS];
    logic [DATA_W-1:0] grp_next [NUM_GROUPS];

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_next[g] = '0;
            for (int j = 0; j < GROUP_SIZE; j++)
            begin
                if (g * GROUP_SIZE + j < NUM_CELLS)
                    grp_next[g] = grp_next[g] | hit_data[g * GROUP_SIZE + j];
            end
        end
    end

    // group words hold while the result waits for the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
                grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        gather_data = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
            gather_data = gather_data | grp_reg[g];
    end

endmodule

// ===== rtl/core/positional_list_table_unit.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | req_type, position, value
// out     | output    | out_valid / out_ready| status, read_value, entry_count
//
// Each transaction passes through accept (cells shift or capture), group
// gather and result load, in that order. The read path through the two-level OR tree sets these steps.
// A new request is taken as soon as the previous result sits in the output
// register, even while out_ready is low; the result load waits for a free slot.
// rst_n clears the count and the handshake state; slot contents stay undefined.
// Depends on plt_pkg, plt_cell, plt_gather.
module positional_list_table_unit
    import plt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int IDX_W    = $clog2(CAPACITY),
    parameter int CNT_W    = $clog2(CAPACITY + 1)
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [TYPE_W-1:0]   req_type,
    input  logic signed [POS_W-1:0]  position,
    input  logic signed [DATA_W-1:0] value,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic signed [DATA_W-1:0] read_value,
    output logic [CNT_W-1:0]    entry_count
);

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_GATHER = 2'd1;
    localparam logic [1:0] PH_OUT    = 2'd2;

    localparam int POS_U_W = POS_W - 1;

    logic [1:0]          phase_reg;
    logic [1:0]          phase_next;
    logic [CNT_W-1:0]    len_reg;
    logic [CNT_W-1:0]    len_next;
    logic [STATUS_W-1:0] st_reg;
    logic [STATUS_W-1:0] st_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic [STATUS_W-1:0] out_st_reg;
    logic [DATA_W-1:0]   out_rv_reg;
    logic [CNT_W-1:0]    out_cnt_reg;

    logic                accept;
    logic                out_load;
    logic                grp_load;
    logic                full;
    logic                pos_neg;
    logic [POS_U_W-1:0]  pos_u;
    logic [POS_U_W-1:0]  len_ext;
    logic                in_range;
    logic [IDX_W-1:0]    ins_at;
    logic [IDX_W-1:0]    at;
    cell_ctrl_t          ctrl;

    logic [DATA_W-1:0]   slot_data [CAPACITY];
    logic [DATA_W-1:0]   hit_data  [CAPACITY];
    logic [DATA_W-1:0]   gather_data;

    assign in_ready = (phase_reg == PH_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_load = (phase_reg == PH_OUT) && (!out_valid_reg || out_ready);
    assign grp_load = (phase_reg == PH_GATHER);

    assign full     = (len_reg == CNT_W'(CAPACITY));
    assign pos_neg  = position[POS_W-1];
    assign pos_u    = position[POS_U_W-1:0];
    assign len_ext  = POS_U_W'(len_reg);
    assign in_range = !pos_neg && (pos_u < len_ext);

    // head for non-positive positions, tail when past the end
    always_comb
    begin
        if (pos_neg)
            ins_at = '0;
        else if (pos_u >= len_ext)
            ins_at = len_reg[IDX_W-1:0];
        else
            ins_at = pos_u[IDX_W-1:0];
    end

    always_comb
    begin
        ctrl     = '0;
        at       = pos_u[IDX_W-1:0];
        len_next = len_reg;
        st_next  = st_reg;
        if (accept)
        begin
            case (req_type)
                REQ_APPEND:
                begin
                    at = len_reg[IDX_W-1:0];
                    if (full)
                        st_next = ST_FULL;
                    else
                    begin
                        st_next  = ST_OK;
                        ctrl.ins = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                REQ_INSERT:
                begin
                    at = ins_at;
                    if (full)
                        st_next = ST_FULL;
                    else
                    begin
                        st_next  = ST_OK;
                        ctrl.ins = 1'b1;
                        len_next = len_reg + 1'b1;
                    end
                end
                REQ_READ:
                begin
                    if (in_range)
                    begin
                        st_next = ST_OK;
                        ctrl.rd = 1'b1;
                    end
                    else
                        st_next = ST_RANGE;
                end
                REQ_REMOVE:
                begin
                    if (in_range)
                    begin
                        st_next  = ST_OK;
                        ctrl.rem = 1'b1;
                        len_next = len_reg - 1'b1;
                    end
                    else
                        st_next = ST_RANGE;
                end
                REQ_CLEAR:
                begin
                    st_next  = ST_OK;
                    len_next = '0;
                end
                default:
                begin
                    st_next = ST_RANGE;
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                    phase_next = PH_GATHER;
            end
            PH_GATHER:
            begin
                phase_next = PH_OUT;
            end
            PH_OUT:
            begin
                if (out_load)
                    phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // transaction metadata and result payload
    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
        if (out_load)
        begin
            out_st_reg  <= st_reg;
            out_rv_reg  <= gather_data;
            out_cnt_reg <= len_reg;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;

            if (i == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_lo
                assign prev_d = slot_data[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign next_d = '0;
            end
            else
            begin : g_mid_hi
                assign next_d = slot_data[i+1];
            end

            plt_cell #(
                .IDX_W (IDX_W),
                .IDX   (i)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .at        (at),
                .wr_data   (value),
                .prev_data (prev_d),
                .next_data (next_d),
                .slot_data (slot_data[i]),
                .hit_data  (hit_data[i])
            );
        end
    endgenerate

    plt_gather #(
        .NUM_CELLS (CAPACITY)
    ) u_gather (
        .clk         (clk),
        .load        (grp_load),
        .hit_data    (hit_data),
        .gather_data (gather_data)
    );

    assign out_valid   = out_valid_reg;
    assign status      = out_st_reg;
    assign read_value  = out_rv_reg;
    assign entry_count = out_cnt_reg;

endmodule
